// ----- rtl/pngu_pkg.sv -----
// Package for the PNG scanline unfilter unit: filter codes, config register
// indexes and the Paeth predictor. No dependencies.
`default_nettype none

package pngu_pkg;

    localparam int BYTE_W = 8;
    localparam int FT_W   = 3;
    localparam int CFG_W  = 14;
    localparam int PIX_W  = 14;
    localparam int BPP_W  = 4;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [FT_W-1:0]   t_filter;

    localparam t_filter FT_NONE  = 3'd0;
    localparam t_filter FT_SUB   = 3'd1;
    localparam t_filter FT_UP    = 3'd2;
    localparam t_filter FT_AVG   = 3'd3;
    localparam t_filter FT_PAETH = 3'd4;

    typedef enum logic {
        CFG_ROW_PIXELS  = 1'b0,
        CFG_PIXEL_BYTES = 1'b1
    } t_cfg_idx;

    // Nearest of a, b, c to a + b - c; ties go to a, then b.
    function automatic t_byte paeth_pick(input t_byte a, input t_byte b, input t_byte c);
        logic signed [10:0] sa;
        logic signed [10:0] sb;
        logic signed [10:0] sc;
        logic signed [10:0] dpa;
        logic signed [10:0] dpb;
        logic signed [10:0] dpc;
        logic [10:0]        pa;
        logic [10:0]        pb;
        logic [10:0]        pc;
        t_byte              pick;
        sa  = $signed({3'b000, a});
        sb  = $signed({3'b000, b});
        sc  = $signed({3'b000, c});
        dpa = sb - sc;
        dpb = sa - sc;
        dpc = sa + sb - sc - sc;
        pa  = dpa[10] ? 11'(-dpa) : 11'(dpa);
        pb  = dpb[10] ? 11'(-dpb) : 11'(dpb);
        pc  = dpc[10] ? 11'(-dpc) : 11'(dpc);
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/png_scanline_unfilter_unit.sv -----
// PNG scanline unfilter unit: rebuilds raw bytes from filtered bytes using a
// line buffer memory for the prior row. Depends on pngu_pkg.
// Throughput is one byte per clock unless the output stalls: a transaction is
// accepted together with its line buffer read, is predicted in stage 1, and is
// written back when it moves on into the output register. The input
// stalls only while stage 1 holds a transaction behind a stalled output
// register. The line buffer is a single-port-read, single-port-write
// memory of MAX_ROW_BYTES bytes; a write-to-read forward covers rows of one
// byte. The buffer has no clearing pass and needs none: a row is always
// written before the next row reads it. Configuration takes effect on the
// next transaction and must be written while no transaction is in flight.
`default_nettype none

module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_index,
    input  wire logic [pngu_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pngu_pkg::BYTE_W-1:0] i_filtered_byte,
    input  wire logic [pngu_pkg::FT_W-1:0]   i_filter_type,
    input  wire logic                        i_image_start,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [pngu_pkg::BYTE_W-1:0]      o_pixel_byte,
    output logic                             o_row_end,
    output logic                             o_bad_filter
);

    localparam int PW   = $clog2(MAX_ROW_BYTES);
    localparam int RLW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int PRW  = pngu_pkg::PIX_W + pngu_pkg::BPP_W;
    localparam int MPB  = MAX_PIXEL_BYTES;
    localparam int SW   = (MPB > 1) ? $clog2(MPB) : 1;
    localparam int BW   = pngu_pkg::BPP_W;

    // config registers
    logic [pngu_pkg::PIX_W-1:0] r_row_pixels;
    logic [BW-1:0]              r_pixel_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pixels  <= pngu_pkg::PIX_W'(1);
            r_pixel_bytes <= BW'(1);
        end else if (i_cfg_wr_en) begin
            unique case (pngu_pkg::t_cfg_idx'(i_cfg_index))
                pngu_pkg::CFG_ROW_PIXELS:  r_row_pixels  <= i_cfg_data[pngu_pkg::PIX_W-1:0];
                pngu_pkg::CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // effective row geometry
    logic [BW-1:0]              bpp_eff;
    logic [pngu_pkg::PIX_W-1:0] pix_eff;
    logic [PRW-1:0]             row_prod;
    logic [RLW-1:0]             row_len;
    logic [RLW-1:0]             bpp_ext;

    always_comb begin
        if (r_pixel_bytes == '0) begin
            bpp_eff = BW'(1);
        end else if (r_pixel_bytes > BW'(MPB)) begin
            bpp_eff = BW'(MPB);
        end else begin
            bpp_eff = r_pixel_bytes;
        end
        pix_eff  = (r_row_pixels == '0) ? pngu_pkg::PIX_W'(1) : r_row_pixels;
        row_prod = PRW'(pix_eff) * PRW'(bpp_eff);
        row_len  = (row_prod > PRW'(MAX_ROW_BYTES)) ? RLW'(MAX_ROW_BYTES)
                                                     : RLW'(row_prod);
        bpp_ext  = RLW'(bpp_eff);
    end

    // pipeline control
    logic r_s1_vld;
    logic r_out_vld;
    logic s1_move;
    logic in_accept;

    assign s1_move    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;

    // row position state
    logic [PW-1:0] r_byte_pos;
    logic          r_first_row;
    logic [SW-1:0] r_mod [MPB];

    logic [PW-1:0] n_pos;
    logic [SW-1:0] n_slot;
    logic          n_first;
    logic          n_last;
    logic          n_haslft;
    logic [PW-1:0] pos_raw;
    logic [SW-1:0] mod_cur [MPB];

    always_comb begin
        pos_raw = i_image_start ? '0 : r_byte_pos;
        n_first = i_image_start ? 1'b1 : r_first_row;
        for (int k = 0; k < MPB; k++) begin
            mod_cur[k] = i_image_start ? '0 : r_mod[k];
        end
        // a row that shrank below the position ends at once on its last byte
        if (RLW'(pos_raw) >= row_len) begin
            n_pos  = PW'(row_len - RLW'(1));
            n_slot = SW'(bpp_eff - BW'(1));
        end else begin
            n_pos  = pos_raw;
            n_slot = mod_cur[SW'(bpp_eff - BW'(1))];
        end
        n_last   = (RLW'(n_pos) + RLW'(1)) >= row_len;
        n_haslft = RLW'(n_pos) >= bpp_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_first_row <= 1'b1;
            for (int k = 0; k < MPB; k++) begin
                r_mod[k] <= '0;
            end
        end else if (in_accept) begin
            if (n_last) begin
                r_byte_pos  <= '0;
                r_first_row <= 1'b0;
                for (int k = 0; k < MPB; k++) begin
                    r_mod[k] <= '0;
                end
            end else begin
                r_byte_pos  <= n_pos + PW'(1);
                r_first_row <= n_first;
                for (int k = 0; k < MPB; k++) begin
                    r_mod[k] <= (mod_cur[k] == SW'(k)) ? '0 : mod_cur[k] + SW'(1);
                end
            end
        end
    end

    // stage 1 transaction
    pngu_pkg::t_byte   r_s1_byte;
    pngu_pkg::t_filter r_s1_ft;
    logic              r_s1_start;
    logic              r_s1_first;
    logic              r_s1_haslft;
    logic              r_s1_last;
    logic [PW-1:0]     r_s1_pos;
    logic [SW-1:0]     r_s1_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_byte   <= i_filtered_byte;
            r_s1_ft     <= i_filter_type;
            r_s1_start  <= i_image_start;
            r_s1_first  <= n_first;
            r_s1_haslft <= n_haslft;
            r_s1_last   <= n_last;
            r_s1_pos    <= n_pos;
            r_s1_slot   <= n_slot;
        end
    end

    // line buffer
    pngu_pkg::t_byte r_line_mem [MAX_ROW_BYTES];
    pngu_pkg::t_byte r_rd_data;
    pngu_pkg::t_byte r_fwd_data;
    logic            r_fwd_hit;
    pngu_pkg::t_byte s1_result;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= r_line_mem[n_pos];
        end
        if (s1_move) begin
            r_line_mem[r_s1_pos] <= s1_result;
        end
    end

    // write and read of one entry at the same edge: forward the new byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (in_accept) begin
            r_fwd_hit <= s1_move && (r_s1_pos == n_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data <= s1_result;
        end
    end

    // pixel histories
    pngu_pkg::t_byte r_left_hist [MPB];
    pngu_pkg::t_byte r_upl_hist  [MPB];

    pngu_pkg::t_byte up_b;
    pngu_pkg::t_byte left_b;
    pngu_pkg::t_byte upl_b;
    pngu_pkg::t_byte pred;
    logic [8:0]      avg_sum;
    logic            s1_bad;

    always_comb begin
        up_b    = r_s1_first ? '0 : (r_fwd_hit ? r_fwd_data : r_rd_data);
        left_b  = r_s1_haslft ? r_left_hist[r_s1_slot] : '0;
        upl_b   = (r_s1_haslft && !r_s1_first) ? r_upl_hist[r_s1_slot] : '0;
        avg_sum = {1'b0, left_b} + {1'b0, up_b};
        s1_bad  = 1'b0;
        unique case (r_s1_ft)
            pngu_pkg::FT_NONE:  pred = '0;
            pngu_pkg::FT_SUB:   pred = left_b;
            pngu_pkg::FT_UP:    pred = up_b;
            pngu_pkg::FT_AVG:   pred = avg_sum[8:1];
            pngu_pkg::FT_PAETH: pred = pngu_pkg::paeth_pick(left_b, up_b, upl_b);
            default: begin
                pred   = '0;
                s1_bad = 1'b1;
            end
        endcase
        s1_result = r_s1_byte + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MPB; k++) begin
                r_left_hist[k] <= '0;
                r_upl_hist[k]  <= '0;
            end
        end else if (s1_move) begin
            if (r_s1_start) begin
                for (int k = 0; k < MPB; k++) begin
                    r_left_hist[k] <= (SW'(k) == r_s1_slot) ? s1_result : '0;
                    r_upl_hist[k]  <= (SW'(k) == r_s1_slot) ? up_b : '0;
                end
            end else begin
                r_left_hist[r_s1_slot] <= s1_result;
                r_upl_hist[r_s1_slot]  <= up_b;
            end
        end
    end

    // output register
    pngu_pkg::t_byte r_out_byte;
    logic            r_out_end;
    logic            r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_byte <= s1_result;
            r_out_end  <= r_s1_last;
            r_out_bad  <= s1_bad;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_pixel_byte = r_out_byte;
    assign o_row_end    = r_out_end;
    assign o_bad_filter = r_out_bad;

    // assertions
    a_start_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && r_s1_start |-> r_s1_pos == '0)
        else $error("image start transaction not at row position zero");

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !r_s1_haslft |-> RLW'(r_s1_pos) < bpp_ext)
        else $error("left neighbor dropped past the first pixel");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> BW'(r_s1_slot) < bpp_eff)
        else $error("history slot beyond pixel size");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(s1_move))
        else $error("output became valid without a stage 1 transfer");

endmodule

`default_nettype wire
